### sv/i2cmbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_pkg - shared types and constants of the I2C master byte engine
// Command codes, the request and result beats, and fixed field widths.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

	localparam int PHASE_W = 16;
	localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 16'd2;

	localparam logic [2:0] OP_START   = 3'd0;
	localparam logic [2:0] OP_RESTART = 3'd1;
	localparam logic [2:0] OP_STOP    = 3'd2;
	localparam logic [2:0] OP_SEND    = 3'd3;
	localparam logic [2:0] OP_RECV    = 3'd4;

	localparam logic       REQ_TICK = 1'b0;
	localparam logic       REQ_CMD  = 1'b1;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic       req_type;
		logic [2:0] op;
		logic [7:0] tx_data;
		logic       ack_to_send;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rx_data;
		logic       nack;
		logic       rejected;
	} res_t;

endpackage

### sv/i2cmbe_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_seq - bus sequencer of the I2C master byte engine
// Holds the command state and steps it by one request beat per advance.
// ----------------------------------------------------------------------------
module i2cmbe_seq #(
	parameter int TICK_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [TICK_WIDTH-1:0] lim,
	input  i2cmbe_pkg::req_t      req,
	output i2cmbe_pkg::res_t      res
);
	import i2cmbe_pkg::*;

	localparam int CntW = TICK_WIDTH + 1;

	typedef enum logic [2:0] {
		ST_START, ST_RESTART, ST_STOP, ST_SEND, ST_RECV, ST_IDLE
	} state_t;

	state_t                st_q, st_d;
	logic [2:0]            step_q, step_d;
	logic [3:0]            bit_q, bit_d, bit_inc;
	logic [7:0]            shift_q, shift_d;
	logic [TICK_WIDTH-1:0] tick_q, tick_d;
	logic                  scl_q, scl_d, sda_q, sda_d;
	logic                  ack_q, ack_d, nack_q, nack_d;
	logic [7:0]            rx_q, rx_d;
	logic                  busy, phase_end, done, rejected;

	assign busy      = (st_q != ST_IDLE);
	assign bit_inc   = 4'(bit_q + 4'd1);
	assign phase_end = ({1'b0, tick_q} + CntW'(1)) >= {1'b0, lim};

	always_comb begin
		st_d     = st_q;
		step_d   = step_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		tick_d   = tick_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		ack_d    = ack_q;
		nack_d   = nack_q;
		rx_d     = rx_q;
		done     = 1'b0;
		rejected = 1'b0;
		if (req.req_type == REQ_CMD) begin
			if (busy) begin
				rejected = 1'b1;
			end else begin
				tick_d = '0;
				bit_d  = '0;
				step_d = 3'd0;
				unique case (req.op)
					OP_START: begin
						st_d    = ST_START;
						shift_d = '0;
						scl_d   = 1'b1;
						sda_d   = 1'b1;
					end
					OP_RESTART: begin
						st_d    = ST_RESTART;
						shift_d = '0;
						scl_d   = 1'b1;
					end
					OP_STOP: begin
						st_d    = ST_STOP;
						shift_d = '0;
						sda_d   = 1'b0;
					end
					OP_SEND: begin
						st_d = ST_SEND;
						// skip the prelude phases whose level is already low
						if (sda_q) begin
							sda_d   = 1'b0;
							shift_d = req.tx_data;
						end else if (scl_q) begin
							scl_d   = 1'b0;
							step_d  = 3'd1;
							shift_d = req.tx_data;
						end else begin
							sda_d   = req.tx_data[7];
							shift_d = {req.tx_data[6:0], 1'b0};
							scl_d   = 1'b1;
							step_d  = 3'd2;
						end
					end
					OP_RECV: begin
						st_d    = ST_RECV;
						shift_d = '0;
						ack_d   = req.ack_to_send;
						scl_d   = 1'b1;
					end
					default: begin
						// unknown command: drop without effect
						tick_d = tick_q;
						bit_d  = bit_q;
						step_d = step_q;
					end
				endcase
			end
		end else if (busy) begin
			if (st_q == ST_SEND && step_q == 3'd5 && tick_q == '0) begin
				nack_d = req.sda_in;
			end
			if (!phase_end) begin
				tick_d = TICK_WIDTH'(tick_q + TICK_WIDTH'(1));
			end else begin
				tick_d = '0;
				step_d = 3'(step_q + 3'd1);
				unique case (st_q)
					ST_START: begin
						case (step_q)
							3'd0:    sda_d = 1'b0;
							3'd1:    scl_d = 1'b0;
							default: done  = 1'b1;
						endcase
					end
					ST_RESTART: done = 1'b1;
					ST_STOP: begin
						case (step_q)
							3'd0:    scl_d = 1'b1;
							3'd1:    sda_d = 1'b1;
							default: done  = 1'b1;
						endcase
					end
					ST_SEND: begin
						case (step_q)
							3'd0: begin
								if (scl_q) begin
									scl_d = 1'b0;
								end else begin
									sda_d   = shift_q[7];
									shift_d = {shift_q[6:0], 1'b0};
									scl_d   = 1'b1;
									step_d  = 3'd2;
								end
							end
							3'd1, 3'd3: begin
								if (step_q == 3'd3) begin
									bit_d = bit_inc;
								end
								if (step_q == 3'd1 || bit_inc < BITS_PER_BYTE) begin
									sda_d   = shift_q[7];
									shift_d = {shift_q[6:0], 1'b0};
									scl_d   = 1'b1;
									step_d  = 3'd2;
								end else begin
									sda_d = 1'b1;
								end
							end
							3'd2:    scl_d = 1'b0;
							3'd4:    scl_d = 1'b1;
							3'd5:    scl_d = 1'b0;
							default: done  = 1'b1;
						endcase
					end
					ST_RECV: begin
						case (step_q)
							3'd0: begin
								shift_d = {shift_q[6:0], req.sda_in};
								scl_d   = 1'b0;
							end
							3'd1: begin
								bit_d = bit_inc;
								if (bit_inc < BITS_PER_BYTE) begin
									scl_d  = 1'b1;
									step_d = 3'd0;
								end else begin
									sda_d = ~ack_q;
								end
							end
							3'd2:    scl_d = 1'b1;
							3'd3: begin
								scl_d = 1'b0;
								sda_d = 1'b1;
							end
							default: begin
								rx_d = shift_q;
								done = 1'b1;
							end
						endcase
					end
					default: done = 1'b0;
				endcase
				if (done) begin
					st_d   = ST_IDLE;
					step_d = 3'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			step_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			tick_q  <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			nack_q  <= 1'b0;
			rx_q    <= '0;
		end else if (advance) begin
			st_q    <= st_d;
			step_q  <= step_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			tick_q  <= tick_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			ack_q   <= ack_d;
			nack_q  <= nack_d;
			rx_q    <= rx_d;
		end
	end

	always_comb begin
		res.scl      = scl_d;
		res.sda      = sda_d;
		res.busy     = (st_d != ST_IDLE);
		res.done     = done;
		res.rx_data  = rx_d;
		res.nack     = nack_d;
		res.rejected = rejected;
	end

endmodule

### sv/i2c_master_byte_engine.sv
// Pipeline: a request beat loads into the request register when taken; its result
// loads into the result register once that register is empty or being taken.
// Throughput: one request beat per cycle while the result side is not stalled;
// the phase update is a single pass of the sequencer between the two registers.
// Reset: bus levels released high, no command running, phase length 2 ticks.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine - byte-level I2C master
// Runs start, restart, stop, send-byte and receive-byte commands, advanced by
// tick beats that carry the sampled SDA level; every beat yields one result.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine #(
	parameter int TICK_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel: ticks per phase
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [i2cmbe_pkg::PHASE_W-1:0] cfg_data,
	// request channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [2:0]                     op,
	input  logic [7:0]                     tx_data,
	input  logic                           ack_to_send,
	input  logic                           sda_in,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           scl_out,
	output logic                           sda_out,
	output logic                           busy_res,
	output logic                           done_res,
	output logic [7:0]                     rx_data,
	output logic                           nack,
	output logic                           cmd_rejected
);
	import i2cmbe_pkg::*;

	logic [TICK_WIDTH-1:0] lim_q, lim_raw, lim_d;
	logic                  valid_s1, valid_s2;
	req_t                  req_s1;
	res_t                  res_next, res_s2;
	logic                  advance;

	// Phase length: saturate to the counter range, treat zero as one.
	generate
		if (TICK_WIDTH < PHASE_W) begin : g_sat
			assign lim_raw = (|cfg_data[PHASE_W-1:TICK_WIDTH]) ? '1
			                                                   : cfg_data[TICK_WIDTH-1:0];
		end else begin : g_ext
			assign lim_raw = TICK_WIDTH'(cfg_data);
		end
	endgenerate

	assign lim_d     = (lim_raw == '0) ? TICK_WIDTH'(1) : lim_raw;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= TICK_WIDTH'(PHASE_TICKS_RST);
		end else if (cfg_valid) begin
			lim_q <= lim_d;
		end
	end

	// Advance the held request into the result register whenever that
	// register is empty or its beat is being taken; accept a new request
	// whenever the request register frees up in the same edge.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.req_type    <= req_type;
			req_s1.op          <= op;
			req_s1.tx_data     <= tx_data;
			req_s1.ack_to_send <= ack_to_send;
			req_s1.sda_in      <= sda_in;
		end
	end

	// Sequencer: state moves only when its result is loaded.
	i2cmbe_seq #(
		.TICK_WIDTH(TICK_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.lim    (lim_q),
		.req    (req_s1),
		.res    (res_next)
	);

	// Result register: hold the beat until taken, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid    = valid_s2;
	assign scl_out      = res_s2.scl;
	assign sda_out      = res_s2.sda;
	assign busy_res     = res_s2.busy;
	assign done_res     = res_s2.done;
	assign rx_data      = res_s2.rx_data;
	assign nack         = res_s2.nack;
	assign cmd_rejected = res_s2.rejected;

	// A finished command leaves the engine idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.done |-> !res_s2.busy)
		else $error("done reported while still busy");

	// A rejected command only happens while another one runs on.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.rejected |-> res_s2.busy && !res_s2.done)
		else $error("rejection reported without a running command");

	// The phase length never reaches the sequencer as zero.
	a_lim_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lim_q != '0)
		else $error("phase length register holds zero");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the I2C master byte engine
// Drives command and tick beats through the request channel and rewrites the
// phase length between bursts of traffic. A shadow sequencer predicts the bus
// levels and status that each beat returns, and every result beat is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
import i2cmbe_pkg::*;

class i2c_byte_scoreboard;

	localparam int TICK_W = 16;
	// sequencer steps with behaviour of their own
	localparam int SEND_BIT_LOW  = 3;
	localparam int SEND_ACK_HIGH = 5;
	localparam int RECV_BIT_HIGH = 0;
	localparam int RECV_BIT_LOW  = 1;

	logic [PHASE_W-1:0] phase_len;
	bit                 running;
	logic [2:0]         cur_op;
	int                 phase_idx;
	logic [3:0]         bit_cnt;
	logic [7:0]         shreg;
	int                 tick_cnt;
	logic               scl_lvl;
	logic               sda_lvl;
	logic               ack_sel;
	logic               nack_flag;
	logic [7:0]         rx_hold;
	res_t               bus_results[$];
	int                 errors;
	int                 result_no;

	function new();
		phase_len = PHASE_TICKS_RST;
		running   = 1'b0;
		cur_op    = OP_START;
		phase_idx = 0;
		bit_cnt   = '0;
		shreg     = '0;
		tick_cnt  = 0;
		scl_lvl   = 1'b1;
		sda_lvl   = 1'b1;
		ack_sel   = 1'b0;
		nack_flag = 1'b0;
		rx_hold   = '0;
		errors    = 0;
		result_no = 0;
	endfunction

	function void set_phase(logic [PHASE_W-1:0] v);
		phase_len = v;
	endfunction

	function int pending();
		return bus_results.size();
	endfunction

	function int tick_limit();
		longint lim;
		lim = phase_len;
		if (lim > (64'd1 << TICK_W) - 1)
			lim = (64'd1 << TICK_W) - 1;
		if (lim == 0)
			lim = 1;
		return int'(lim);
	endfunction

	// 1: a phase begins, 0: nothing to wait for here, -1: sequence over
	function int run_action(int step);
		case (cur_op)
		OP_START: begin
			case (step)
			0: begin
				scl_lvl = 1'b1;
				sda_lvl = 1'b1;
				return 1;
			end
			1: begin
				sda_lvl = 1'b0;
				return 1;
			end
			2: begin
				scl_lvl = 1'b0;
				return 1;
			end
			default: return -1;
			endcase
		end
		OP_RESTART: begin
			if (step == 0) begin
				scl_lvl = 1'b1;
				return 1;
			end
			return -1;
		end
		OP_STOP: begin
			case (step)
			0: begin
				sda_lvl = 1'b0;
				return 1;
			end
			1: begin
				scl_lvl = 1'b1;
				return 1;
			end
			2: begin
				sda_lvl = 1'b1;
				return 1;
			end
			default: return -1;
			endcase
		end
		OP_SEND: begin
			case (step)
			0: begin
				if (sda_lvl) begin
					sda_lvl = 1'b0;
					return 1;
				end
				return 0;
			end
			1: begin
				if (scl_lvl) begin
					scl_lvl = 1'b0;
					return 1;
				end
				return 0;
			end
			2: begin
				sda_lvl = shreg[7];
				shreg   = {shreg[6:0], 1'b0};
				scl_lvl = 1'b1;
				return 1;
			end
			3: begin
				scl_lvl = 1'b0;
				return 1;
			end
			4: begin
				sda_lvl = 1'b1;
				return 1;
			end
			5: begin
				scl_lvl = 1'b1;
				return 1;
			end
			6: begin
				scl_lvl = 1'b0;
				return 1;
			end
			default: return -1;
			endcase
		end
		OP_RECV: begin
			case (step)
			0: begin
				scl_lvl = 1'b1;
				return 1;
			end
			1: begin
				scl_lvl = 1'b0;
				return 1;
			end
			2: begin
				sda_lvl = ~ack_sel;
				return 1;
			end
			3: begin
				scl_lvl = 1'b1;
				return 1;
			end
			4: begin
				scl_lvl = 1'b0;
				sda_lvl = 1'b1;
				return 1;
			end
			default: return -1;
			endcase
		end
		default: return -1;
		endcase
	endfunction

	function bit enter_phase(int step);
		int r;
		while (1) begin
			r = run_action(step);
			if (r == 1) begin
				phase_idx = step;
				tick_cnt  = 0;
				return 1'b1;
			end
			if (r < 0)
				return 1'b0;
			step++;
		end
		return 1'b0;
	endfunction

	function int advance(int step);
		if ((cur_op == OP_SEND && step == SEND_BIT_LOW) ||
		    (cur_op == OP_RECV && step == RECV_BIT_LOW)) begin
			bit_cnt = bit_cnt + 4'd1;
			if (bit_cnt < BITS_PER_BYTE)
				return step - 1;
		end
		return step + 1;
	endfunction

	function void note_request(logic rq, logic [2:0] opc, logic [7:0] txd, logic ack,
	                           logic sdi);
		res_t r;
		int   step;
		logic done;
		logic rej;
		done = 1'b0;
		rej  = 1'b0;
		if (rq == REQ_CMD) begin
			if (running) begin
				rej = 1'b1;
			end else if (opc <= OP_RECV) begin
				cur_op  = opc;
				running = 1'b1;
				bit_cnt = '0;
				shreg   = (opc == OP_SEND) ? txd : 8'h00;
				if (opc == OP_RECV)
					ack_sel = ack;
				if (!enter_phase(0)) begin
					running   = 1'b0;
					phase_idx = 0;
					done      = 1'b1;
				end
			end
		end else if (running) begin
			step = phase_idx;
			if (cur_op == OP_SEND && step == SEND_ACK_HIGH && tick_cnt == 0)
				nack_flag = sdi;
			if (tick_cnt + 1 >= tick_limit()) begin
				if (cur_op == OP_RECV && step == RECV_BIT_HIGH)
					shreg = {shreg[6:0], sdi};
				if (!enter_phase(advance(step))) begin
					if (cur_op == OP_RECV)
						rx_hold = shreg;
					running   = 1'b0;
					phase_idx = 0;
					tick_cnt  = 0;
					done      = 1'b1;
				end
			end else begin
				tick_cnt++;
			end
		end
		r.scl      = scl_lvl;
		r.sda      = sda_lvl;
		r.busy     = running;
		r.done     = done;
		r.rx_data  = rx_hold;
		r.nack     = nack_flag;
		r.rejected = rej;
		bus_results.push_back(r);
	endfunction

	task report(string field, int got, int want);
		if (errors < 60)
			$display("result %0d: %s is %0h, expected %0h", result_no, field, got, want);
		errors++;
	endtask

	task check_result(res_t got);
		res_t want;
		if (bus_results.size() == 0) begin
			report("unexpected beat", 1, 0);
			result_no++;
			return;
		end
		want = bus_results.pop_front();
		if (got.scl !== want.scl)
			report("scl_out", got.scl, want.scl);
		if (got.sda !== want.sda)
			report("sda_out", got.sda, want.sda);
		if (got.busy !== want.busy)
			report("busy_res", got.busy, want.busy);
		if (got.done !== want.done)
			report("done_res", got.done, want.done);
		if (got.rx_data !== want.rx_data)
			report("rx_data", got.rx_data, want.rx_data);
		if (got.nack !== want.nack)
			report("nack", got.nack, want.nack);
		if (got.rejected !== want.rejected)
			report("cmd_rejected", got.rejected, want.rejected);
		result_no++;
	endtask

endclass

module tb;

	localparam int         TICK_W      = 16;
	localparam int         CYCLE_LIMIT = 3000000;
	localparam logic [2:0] OP_LAST     = 3'd7;
	// sda_in patterns for the ticks of one command
	localparam int         SDA_LOW     = 0;
	localparam int         SDA_HIGH    = 1;
	localparam int         SDA_RANDOM  = 2;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [PHASE_W-1:0] cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               req_type;
	logic [2:0]         op;
	logic [7:0]         tx_data;
	logic               ack_to_send;
	logic               sda_in;
	logic               out_valid;
	logic               out_ready;
	logic               scl_out;
	logic               sda_out;
	logic               busy_res;
	logic               done_res;
	logic [7:0]         rx_data;
	logic               nack;
	logic               cmd_rejected;

	i2c_byte_scoreboard sb;
	bit                 quiet;
	int                 beats_sent;
	int                 cycles;
	int                 stall_left;

	i2c_master_byte_engine #(
		.TICK_WIDTH(TICK_W)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.op          (op),
		.tx_data     (tx_data),
		.ack_to_send (ack_to_send),
		.sda_in      (sda_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.scl_out     (scl_out),
		.sda_out     (sda_out),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.rx_data     (rx_data),
		.nack        (nack),
		.cmd_rejected(cmd_rejected)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Guard against a hung handshake: give up well beyond the slowest correct run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side: stall in random bursts, drop stalls once quiet.
	initial begin
		out_ready  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				out_ready = 1'b0;
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready  = 1'b0;
				stall_left = $urandom_range(1, 8) - 1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Sample every result beat at the rising edge and hand it to the scoreboard.
	always @(posedge clk) begin : result_monitor
		res_t got;
		if (arst_n && out_valid && out_ready) begin
			got.scl      = scl_out;
			got.sda      = sda_out;
			got.busy     = busy_res;
			got.done     = done_res;
			got.rx_data  = rx_data;
			got.nack     = nack;
			got.rejected = cmd_rejected;
			sb.check_result(got);
		end
	end

	// Offer one request beat and hold it until taken; called and left at a falling edge.
	task automatic push_item(input logic rq, input logic [2:0] opc, input logic [7:0] txd,
	                         input logic ack, input logic sdi);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid    = 1'b1;
		req_type    = rq;
		op          = opc;
		tx_data     = txd;
		ack_to_send = ack;
		sda_in      = sdi;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(rq, opc, txd, ack, sdi);
		beats_sent++;
		@(negedge clk);
	endtask

	function automatic logic pick_sda(int mode);
		if (mode == SDA_LOW)
			return 1'b0;
		if (mode == SDA_HIGH)
			return 1'b1;
		return 1'($urandom_range(0, 1));
	endfunction

	// Issue one command, then tick until the shadow sequencer reports it finished.
	// Where reject_odds is non-zero, slip in a command while busy about once in that many beats.
	task automatic run_cmd(input logic [2:0] opc, input logic [7:0] txd, input logic ack,
	                       input int sda_mode, input int reject_odds);
		push_item(REQ_CMD, opc, txd, ack, 1'($urandom_range(0, 1)));
		while (sb.running) begin
			if (reject_odds != 0 && $urandom_range(1, reject_odds) == 1)
				push_item(REQ_CMD, 3'($urandom_range(0, OP_LAST)), 8'($urandom),
				          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			else
				push_item(REQ_TICK, 3'($urandom_range(0, OP_LAST)), 8'($urandom),
				          1'($urandom_range(0, 1)), pick_sda(sda_mode));
		end
	endtask

	// Drain every outstanding result, then hold for the pipeline depth and a little more.
	task automatic settle();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_phase(input logic [PHASE_W-1:0] v);
		cfg_valid = 1'b1;
		cfg_data  = v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_phase(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly whole commands with random content; a little noise of idle ticks and
	// undefined opcodes, and commands thrown at the engine while it is busy.
	task automatic random_traffic(input int n);
		int         target;
		int         pick;
		int         w;
		int         mode;
		logic [2:0] opc;
		target = beats_sent + n;
		while (beats_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				push_item(REQ_TICK, 3'($urandom_range(0, OP_LAST)), 8'($urandom),
				          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else if (pick < 9) begin
				push_item(REQ_CMD, 3'($urandom_range(OP_RECV + 1, OP_LAST)), 8'($urandom),
				          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				w = $urandom_range(0, 99);
				if (w < 15)
					opc = OP_START;
				else if (w < 22)
					opc = OP_RESTART;
				else if (w < 35)
					opc = OP_STOP;
				else if (w < 70)
					opc = OP_SEND;
				else
					opc = OP_RECV;
				mode = ($urandom_range(0, 9) == 0) ? $urandom_range(SDA_LOW, SDA_HIGH) : SDA_RANDOM;
				run_cmd(opc, 8'($urandom), 1'($urandom_range(0, 1)), mode, 12);
			end
		end
	endtask

	initial begin
		sb          = new();
		quiet       = 1'b0;
		beats_sent  = 0;
		cycles      = 0;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		req_type    = REQ_TICK;
		op          = OP_START;
		tx_data     = '0;
		ack_to_send = 1'b0;
		sda_in      = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pass at the reset phase length.
		// Ticks and undefined opcodes while idle change nothing.
		push_item(REQ_TICK, OP_START, 8'h00, 1'b0, 1'b0);
		push_item(REQ_TICK, OP_LAST, 8'hFF, 1'b1, 1'b1);
		push_item(REQ_CMD, OP_LAST, 8'hFF, 1'b1, 1'b1);
		push_item(REQ_CMD, OP_RECV + 3'd1, 8'h00, 1'b0, 1'b0);
		// Send straight after start skips the prelude; the ack slot sees high, then low.
		run_cmd(OP_START, 8'h00, 1'b0, SDA_RANDOM, 0);
		run_cmd(OP_SEND, 8'hFF, 1'b0, SDA_HIGH, 0);
		run_cmd(OP_SEND, 8'h00, 1'b1, SDA_LOW, 0);
		// Commands arriving mid-send must be refused.
		run_cmd(OP_SEND, 8'hA5, 1'b0, SDA_RANDOM, 4);
		run_cmd(OP_RESTART, 8'h00, 1'b0, SDA_RANDOM, 0);
		// Receive with ack and with nack, all ones then all zeros on the bus.
		run_cmd(OP_RECV, 8'h00, 1'b1, SDA_HIGH, 0);
		run_cmd(OP_RECV, 8'hFF, 1'b0, SDA_LOW, 0);
		run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
		// After stop both lines are high, so the send prelude runs in full.
		run_cmd(OP_SEND, 8'h5A, 1'b0, SDA_RANDOM, 0);
		run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
		settle();

		// A zero phase length acts as one tick.
		write_phase(16'h0000);
		random_traffic(80);
		settle();

		// A long phase: a lone restart keeps the run short.
		write_phase(16'd40);
		run_cmd(OP_RESTART, 8'h00, 1'b0, SDA_RANDOM, 0);
		push_item(REQ_CMD, OP_LAST, 8'h00, 1'b0, 1'b0);
		settle();

		write_phase(16'd1);
		random_traffic(70);
		settle();

		write_phase(16'd3);
		random_traffic(70);
		settle();

		write_phase(16'($urandom_range(1, 5)));
		random_traffic(50);
		settle();

		// Final stretch with no idling on either side.
		quiet = 1'b1;
		write_phase(PHASE_TICKS_RST);
		random_traffic(50);
		in_valid = 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
